FILE: src/axfd_pkg.sv
// Shared types and constants of the AX.25 frame header decoder.
`default_nettype none

package axfd_pkg;

    localparam int MAX_INFO = 256;

    typedef enum logic [1:0] {
        KIND_CHAR    = 2'd0,
        KIND_SSID    = 2'd1,
        KIND_INFO    = 2'd2,
        KIND_SUMMARY = 2'd3
    } kind_t;

    localparam logic [1:0] SLOT_DEST = 2'd0;
    localparam logic [1:0] SLOT_SRC  = 2'd1;
    localparam logic [1:0] SLOT_VIA  = 2'd2;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_SHORT     = 3'd1;
    localparam logic [2:0] ST_EXTRA_VIA = 3'd2;
    localparam logic [2:0] ST_OVERFLOW  = 3'd3;
    localparam logic [2:0] ST_BAD_U     = 3'd4;
    localparam logic [2:0] ST_BAD_S     = 3'd5;

    localparam logic [3:0] FT_I     = 4'd0;
    localparam logic [3:0] FT_RR    = 4'd1;
    localparam logic [3:0] FT_RNR   = 4'd2;
    localparam logic [3:0] FT_REJ   = 4'd3;
    localparam logic [3:0] FT_SREJ  = 4'd4;
    localparam logic [3:0] FT_SABME = 4'd5;
    localparam logic [3:0] FT_SABM  = 4'd6;
    localparam logic [3:0] FT_DISC  = 4'd7;
    localparam logic [3:0] FT_DM    = 4'd8;
    localparam logic [3:0] FT_UA    = 4'd9;
    localparam logic [3:0] FT_FRMR  = 4'd10;
    localparam logic [3:0] FT_UI    = 4'd11;
    localparam logic [3:0] FT_XID   = 4'd12;
    localparam logic [3:0] FT_TEST  = 4'd13;

    typedef struct packed {
        kind_t       kind;
        logic [1:0]  slot;
        logic [7:0]  value;
        logic [2:0]  status;
        logic [3:0]  ctrl_type;
        logic        command_bit;
        logic        poll_final;
        logic [2:0]  recv_seq;
        logic [2:0]  send_seq;
        logic        via_repeated;
        logic [8:0]  info_count;
        logic        last_result;
    } result_t;

    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } push_t;

endpackage

`default_nettype wire

FILE: src/axfd_decode.sv
// Input register, per-frame state and byte decode of the frame header decoder.
`default_nettype none

module axfd_decode (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire logic [7:0]      frame_byte,
    input  wire logic            last_byte,
    input  wire logic [8:0]      info_limit,
    input  wire logic            room,
    output axfd_pkg::push_t      push
);
    import axfd_pkg::*;

    localparam logic [8:0] LIMIT_CAP = (MAX_INFO > 511) ? 9'd511 : 9'(MAX_INFO);

    logic       hold_valid_reg, hold_valid_next;
    logic [7:0] byte_reg;
    logic       last_reg;

    logic [8:0] byte_index_reg, byte_index_next;
    logic       space_seen_reg, space_seen_next;
    logic       dest_cmd_reg, dest_cmd_next;
    logic       has_via_reg, has_via_next;
    logic       via_h_bit_reg, via_h_bit_next;
    logic [7:0] control_reg, control_next;
    logic [7:0] pid_reg, pid_next;
    logic [2:0] error_reg, error_next;
    logic [3:0] type_reg, type_next;
    logic [8:0] data_count_reg, data_count_next;

    logic       accept, advance;
    logic       in_addr, short_frame, ss, ra_valid;
    logic [1:0] slot;
    logic [4:0] pos_wide;
    logic [2:0] pos;
    logic [6:0] ch;
    logic [8:0] ctl, limit;
    logic [4:0] cls;
    logic [2:0] status;
    result_t    ra, sum;

    // [4] set for an unknown code, [3:0] the frame type
    function automatic logic [4:0] classify(input logic [7:0] c);
        logic [4:0] r;
        r = {1'b0, FT_I};
        if (c[0] == 1'b0)
        begin
            r = {1'b0, FT_I};
        end
        else if (c[1:0] == 2'b11)
        begin
            case (c & 8'hEF)
                8'h6F:   r = {1'b0, FT_SABME};
                8'h2F:   r = {1'b0, FT_SABM};
                8'h43:   r = {1'b0, FT_DISC};
                8'h0F:   r = {1'b0, FT_DM};
                8'h63:   r = {1'b0, FT_UA};
                8'h87:   r = {1'b0, FT_FRMR};
                8'h03:   r = {1'b0, FT_UI};
                8'hAF:   r = {1'b0, FT_XID};
                8'hE3:   r = {1'b0, FT_TEST};
                default: r = {1'b1, 4'd0};
            endcase
        end
        else
        begin
            case (c[3:0])
                4'h1:    r = {1'b0, FT_RR};
                4'h5:    r = {1'b0, FT_RNR};
                4'h9:    r = {1'b0, FT_REJ};
                4'hD:    r = {1'b0, FT_SREJ};
                default: r = {1'b1, 4'd0};
            endcase
        end
        return r;
    endfunction

    assign advance  = hold_valid_reg && room;
    assign in_ready = !hold_valid_reg || room;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        if (accept)
        begin
            hold_valid_next = 1'b1;
        end
        else if (advance)
        begin
            hold_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            byte_reg <= frame_byte;
            last_reg <= last_byte;
        end
    end

    assign limit = (info_limit < LIMIT_CAP) ? info_limit : LIMIT_CAP;
    assign ctl   = has_via_reg ? 9'd21 : 9'd14;
    assign ch    = byte_reg[7:1];
    assign cls   = classify(byte_reg);

    always_comb
    begin
        if (byte_index_reg < 9'd7)
        begin
            slot = SLOT_DEST;
        end
        else if (byte_index_reg < 9'd14)
        begin
            slot = SLOT_SRC;
        end
        else
        begin
            slot = SLOT_VIA;
        end
    end

    assign pos_wide = byte_index_reg[4:0]
                    - ((slot == SLOT_DEST) ? 5'd0 : (slot == SLOT_SRC) ? 5'd7 : 5'd14);
    assign pos      = pos_wide[2:0];
    assign in_addr  = (byte_index_reg < 9'd14) || (has_via_reg && byte_index_reg < 9'd21);

    always_comb
    begin
        byte_index_next = byte_index_reg;
        space_seen_next = space_seen_reg;
        dest_cmd_next   = dest_cmd_reg;
        has_via_next    = has_via_reg;
        via_h_bit_next  = via_h_bit_reg;
        control_next    = control_reg;
        pid_next        = pid_reg;
        error_next      = error_reg;
        type_next       = type_reg;
        data_count_next = data_count_reg;
        short_frame     = 1'b0;
        ss              = 1'b0;
        ra_valid        = 1'b0;
        ra              = '0;
        sum             = '0;
        status          = ST_OK;

        if (in_addr)
        begin
            if (error_reg == ST_OK)
            begin
                ss = (pos == 3'd0) ? 1'b0 : space_seen_reg;
                space_seen_next = ss;
                if (pos < 3'd6)
                begin
                    if (ss || ch == 7'h20)
                    begin
                        space_seen_next = 1'b1;
                    end
                    else
                    begin
                        ra_valid = 1'b1;
                        ra.kind  = KIND_CHAR;
                        ra.slot  = slot;
                        ra.value = {1'b0, ch};
                    end
                end
                else
                begin
                    if (byte_reg[4:1] != 4'd0)
                    begin
                        ra_valid = 1'b1;
                        ra.kind  = KIND_SSID;
                        ra.slot  = slot;
                        ra.value = {4'd0, byte_reg[4:1]};
                    end
                    if (slot == SLOT_DEST)
                    begin
                        dest_cmd_next = byte_reg[7];
                    end
                    else if (slot == SLOT_SRC)
                    begin
                        has_via_next = !byte_reg[0];
                    end
                    else
                    begin
                        via_h_bit_next = byte_reg[7];
                        if (!byte_reg[0])
                        begin
                            error_next = ST_EXTRA_VIA;
                        end
                    end
                end
            end
            short_frame = last_reg;
        end
        else if (error_reg == ST_OK || error_reg == ST_OVERFLOW)
        begin
            if (byte_index_reg == ctl)
            begin
                control_next = byte_reg;
                if (cls[4])
                begin
                    error_next = (byte_reg[1:0] == 2'b11) ? ST_BAD_U : ST_BAD_S;
                end
                else
                begin
                    type_next = cls[3:0];
                end
                if (error_next == ST_OK && (type_next == FT_I || type_next == FT_UI)
                    && last_reg)
                begin
                    short_frame = 1'b1;
                end
            end
            else if (type_reg == FT_I || type_reg == FT_UI)
            begin
                if (byte_index_reg == ctl + 9'd1)
                begin
                    pid_next = byte_reg;
                end
                else if (data_count_reg < limit)
                begin
                    ra_valid        = 1'b1;
                    ra.kind         = KIND_INFO;
                    ra.value        = byte_reg;
                    data_count_next = data_count_reg + 9'd1;
                end
                else
                begin
                    error_next = ST_OVERFLOW;
                end
            end
        end

        if (byte_index_reg != 9'd511)
        begin
            byte_index_next = byte_index_reg + 9'd1;
        end

        status           = short_frame ? ST_SHORT : error_next;
        sum.kind         = KIND_SUMMARY;
        sum.status       = status;
        sum.command_bit  = dest_cmd_next;
        sum.via_repeated = via_h_bit_next;
        sum.last_result  = 1'b1;
        if (status == ST_OK)
        begin
            sum.ctrl_type  = type_next;
            sum.poll_final = control_next[4];
            if (type_next <= FT_SREJ)
            begin
                sum.recv_seq = control_next[7:5];
            end
            if (type_next == FT_I)
            begin
                sum.send_seq = control_next[3:1];
            end
            if (type_next == FT_I || type_next == FT_UI)
            begin
                sum.value      = pid_next;
                sum.info_count = data_count_next;
            end
        end

        ra.last_result = !last_reg;

        if (last_reg)
        begin
            byte_index_next = '0;
            space_seen_next = 1'b0;
            dest_cmd_next   = 1'b0;
            has_via_next    = 1'b0;
            via_h_bit_next  = 1'b0;
            control_next    = '0;
            pid_next        = '0;
            error_next      = ST_OK;
            type_next       = FT_I;
            data_count_next = '0;
        end
    end

    always_comb
    begin
        push.count  = 2'd0;
        push.first  = ra_valid ? ra : sum;
        push.second = sum;
        if (advance)
        begin
            push.count = {1'b0, ra_valid} + {1'b0, last_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_index_reg <= '0;
            space_seen_reg <= 1'b0;
            dest_cmd_reg   <= 1'b0;
            has_via_reg    <= 1'b0;
            via_h_bit_reg  <= 1'b0;
            control_reg    <= '0;
            pid_reg        <= '0;
            error_reg      <= ST_OK;
            type_reg       <= FT_I;
            data_count_reg <= '0;
        end
        else if (advance)
        begin
            byte_index_reg <= byte_index_next;
            space_seen_reg <= space_seen_next;
            dest_cmd_reg   <= dest_cmd_next;
            has_via_reg    <= has_via_next;
            via_h_bit_reg  <= via_h_bit_next;
            control_reg    <= control_next;
            pid_reg        <= pid_next;
            error_reg      <= error_next;
            type_reg       <= type_next;
            data_count_reg <= data_count_next;
        end
    end

endmodule

`default_nettype wire

FILE: src/axfd_result_fifo.sv
// Four-entry result queue taking up to two results per cycle, giving one.
`default_nettype none

module axfd_result_fifo (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire axfd_pkg::push_t   push,
    output logic                   room,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output axfd_pkg::result_t      head
);
    import axfd_pkg::*;

    result_t    entries_reg [4];
    logic [1:0] wr_ptr_reg, wr_ptr_next;
    logic [1:0] rd_ptr_reg, rd_ptr_next;
    logic [2:0] count_reg, count_next;
    logic       pop;

    assign out_valid = (count_reg != 3'd0);
    assign pop       = out_valid && out_ready;
    assign room      = (count_reg <= 3'd2);
    assign head      = entries_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + push.count;
        rd_ptr_next = rd_ptr_reg + {1'b0, pop};
        count_next  = count_reg + {1'b0, push.count} - {2'b00, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            entries_reg[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2)
        begin
            entries_reg[wr_ptr_reg + 2'd1] <= push.second;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

FILE: src/ax25_frame_header_decoder_unit.sv
// Top level of the AX.25 frame header decoder: config register, decode and result queue.
// Path: an accepted frame byte is held in the input register of the decode, and its results
//   are written into the result queue once the queue has room, and offered from there.
// Throughput: one frame byte per cycle while the queue has room; it drains one result per
//   cycle, and a final byte may push a character, ssid or info result and its summary.
// Reset: asynchronous, clears frame state and queue, info_limit returns to 256.
`default_nettype none

module ax25_frame_header_decoder_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [8:0]  cfg_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  frame_byte,
    input  wire logic        last_byte,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [1:0]       kind,
    output logic [1:0]       slot,
    output logic [7:0]       value,
    output logic [2:0]       status,
    output logic [3:0]       ctrl_type,
    output logic             command_bit,
    output logic             poll_final,
    output logic [2:0]       recv_seq,
    output logic [2:0]       send_seq,
    output logic             via_repeated,
    output logic [8:0]       info_count,
    output logic             last_result
);
    import axfd_pkg::*;

    logic [8:0] info_limit_reg;
    logic       room;
    push_t      push;
    result_t    head;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            info_limit_reg <= 9'd256;
        end
        else if (cfg_valid && cfg_ready)
        begin
            info_limit_reg <= cfg_data;
        end
    end

    axfd_decode u_decode (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .frame_byte (frame_byte),
        .last_byte  (last_byte),
        .info_limit (info_limit_reg),
        .room       (room),
        .push       (push)
    );

    axfd_result_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .head      (head)
    );

    assign kind         = head.kind;
    assign slot         = head.slot;
    assign value        = head.value;
    assign status       = head.status;
    assign ctrl_type    = head.ctrl_type;
    assign command_bit  = head.command_bit;
    assign poll_final   = head.poll_final;
    assign recv_seq     = head.recv_seq;
    assign send_seq     = head.send_seq;
    assign via_repeated = head.via_repeated;
    assign info_count   = head.info_count;
    assign last_result  = head.last_result;

endmodule

`default_nettype wire
